// ===== design/ssmd_pkg.sv =====
package ssmd_pkg;

    localparam int DIGITS     = 2;
    localparam int DIGIT_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int SEG_W      = 7;
    localparam int EN_W       = 2;
    localparam int SLOT_W     = 16;
    localparam int BRIGHT_W   = 8;
    localparam int PROD_W     = SLOT_W + BRIGHT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // ceil(2^32 / 255): exact quotient by 255 for any product below 2^24
    localparam int RECIP_W             = 25;
    localparam int RECIP_SHIFT         = 32;
    localparam logic [RECIP_W-1:0] RECIP_255 = 25'h101_0102;

    // cycles from a configuration write until the on-time table is current
    localparam int HOLD_CYCLES = 3;
    localparam int HOLD_W      = 2;

    localparam logic [SLOT_W-1:0]   SLOT_RESET   = 16'd1000;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd255;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_DIGIT = 2'd1;
    localparam logic [1:0] OP_RAW   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_ONES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_TENS = 2'd2;

    typedef enum logic [1:0] {
        PH_PRE   = 2'd0,
        PH_ON    = 2'd1,
        PH_OFF   = 2'd2,
        PH_BLANK = 2'd3
    } t_phase;

    // decimal value (mod 10) to segments a..g, bit0 is segment a
    function automatic logic [SEG_W-1:0] digit_mask(input logic [7:0] value);
        logic [15:0] prod;
        logic [4:0]  quo;
        logic [7:0]  rem;
        logic [SEG_W-1:0] mask;
        prod = 16'(value) * 16'd205;
        quo  = prod[15:11];
        rem  = value - ({quo, 3'b000} + {2'b00, quo, 1'b0});
        case (rem)
            8'd0:    mask = 7'h3F;
            8'd1:    mask = 7'h06;
            8'd2:    mask = 7'h5B;
            8'd3:    mask = 7'h4F;
            8'd4:    mask = 7'h66;
            8'd5:    mask = 7'h6D;
            8'd6:    mask = 7'h7D;
            8'd7:    mask = 7'h07;
            8'd8:    mask = 7'h7F;
            8'd9:    mask = 7'h6F;
            default: mask = '0;
        endcase
        return mask;
    endfunction

endpackage

// ===== design/seven_segment_mux_dimmer.sv =====
// An item waits in the input register; a tick's result goes to the output register. These
// are the only stages, and all phase, counter and mask logic sits between them. Throughput:
// one item per cycle while no hold is on and no tick waits on a stalled output register.
// After reset and after each configuration write, input is stalled while the per-digit
// on-time pipeline (multiply, reciprocal multiply, clamp) settles.
// Reset (synchronous, active low) blanks both digits and restarts the scan at the ones digit.
module seven_segment_mux_dimmer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_op,
    input  logic                                  i_position,
    input  logic [7:0]                            i_value,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [ssmd_pkg::SEG_W-1:0]            o_segment_lines,
    output logic [ssmd_pkg::EN_W-1:0]             o_enable_lines,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ssmd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ssmd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ssmd_pkg::SLOT_W-1:0]   r_slot;
    logic [ssmd_pkg::BRIGHT_W-1:0] r_bright [2];
    logic [ssmd_pkg::HOLD_W-1:0]   r_hold;
    logic                          cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= ssmd_pkg::SLOT_RESET;
            r_bright[0] <= ssmd_pkg::BRIGHT_RESET;
            r_bright[1] <= ssmd_pkg::BRIGHT_RESET;
            r_hold    <= ssmd_pkg::HOLD_W'(ssmd_pkg::HOLD_CYCLES);
        end else begin
            if (cfg_write) begin
                case (i_cfg_index)
                    ssmd_pkg::CFG_SLOT:        r_slot      <= i_cfg_data;
                    ssmd_pkg::CFG_BRIGHT_ONES: r_bright[0] <= i_cfg_data[ssmd_pkg::BRIGHT_W-1:0];
                    ssmd_pkg::CFG_BRIGHT_TENS: r_bright[1] <= i_cfg_data[ssmd_pkg::BRIGHT_W-1:0];
                    default: ;
                endcase
            end
            // hold off new items until the on-time table reflects the new settings
            if (cfg_write) begin
                r_hold <= ssmd_pkg::HOLD_W'(ssmd_pkg::HOLD_CYCLES);
            end else if (r_hold != '0) begin
                r_hold <= r_hold - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // On-time pipeline, one lane per brightness register:
    // on = max(1, slot * bright / 255). Runs freely from the config registers.
    // ------------------------------------------------------------------
    logic [ssmd_pkg::PROD_W-1:0] r_prod   [2];
    logic [ssmd_pkg::SLOT_W-1:0] r_quo    [2];
    logic [ssmd_pkg::SLOT_W-1:0] r_on_pre [2];
    logic [ssmd_pkg::PROD_W+ssmd_pkg::RECIP_W-1:0] recip_prod [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            recip_prod[l] = (ssmd_pkg::PROD_W+ssmd_pkg::RECIP_W)'(r_prod[l])
                          * (ssmd_pkg::PROD_W+ssmd_pkg::RECIP_W)'(ssmd_pkg::RECIP_255);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_prod[l]   <= ssmd_pkg::PROD_W'(r_slot) * ssmd_pkg::PROD_W'(r_bright[l]);
            r_quo[l]    <= recip_prod[l][ssmd_pkg::RECIP_SHIFT +: ssmd_pkg::SLOT_W];
            r_on_pre[l] <= (r_quo[l] == '0) ? ssmd_pkg::SLOT_W'(1) : r_quo[l];
        end
    end

    // ------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------
    logic       r_a_valid;
    logic [1:0] r_a_op;
    logic       r_a_pos;
    logic [7:0] r_a_value;
    logic       r_out_valid;
    logic       a_tick;
    logic       out_free;
    logic       a_fire;
    logic       in_take;

    assign a_tick   = (r_a_op == ssmd_pkg::OP_TICK);
    assign out_free = !r_out_valid || !i_stall;
    // a tick needs room in the output register; writes and unused ops just drain
    assign a_fire   = r_a_valid && (!a_tick || out_free);
    assign in_take  = (r_hold == '0) && (!r_a_valid || a_fire);
    assign o_stall  = !in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= i_valid;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_valid) begin
            r_a_op    <= i_op;
            r_a_pos   <= i_position;
            r_a_value <= i_value;
        end
    end

    // ------------------------------------------------------------------
    // Scan state
    // ------------------------------------------------------------------
    logic [ssmd_pkg::SEG_W-1:0]   r_shown   [ssmd_pkg::DIGITS];
    logic [ssmd_pkg::SEG_W-1:0]   r_latched [ssmd_pkg::DIGITS];
    logic [ssmd_pkg::DIGIT_W-1:0] r_digit;
    ssmd_pkg::t_phase             r_phase;
    logic [ssmd_pkg::SLOT_W-1:0]  r_count;
    logic [ssmd_pkg::SLOT_W-1:0]  r_on_ticks;

    ssmd_pkg::t_phase             n_phase;
    logic [ssmd_pkg::SLOT_W-1:0]  n_count;
    logic [ssmd_pkg::DIGIT_W-1:0] n_digit;
    logic [ssmd_pkg::SEG_W-1:0]   n_seg;
    logic [ssmd_pkg::EN_W-1:0]    n_en;

    logic                         slot_start;
    logic [ssmd_pkg::SLOT_W-1:0]  on_cur;
    logic [ssmd_pkg::DIGIT_W-1:0] digit_next;
    logic [ssmd_pkg::SLOT_W:0]    cnt_inc;
    logic [ssmd_pkg::SLOT_W:0]    on_len;
    logic [ssmd_pkg::SLOT_W-1:0]  off_time;
    logic [ssmd_pkg::SLOT_W-1:0]  blank_len;
    logic [ssmd_pkg::SEG_W-1:0]   cur_mask;

    // first tick of a slot: on-time is taken from the table, masks latched for digit 0
    assign slot_start = (r_phase == ssmd_pkg::PH_PRE) && (r_count == '0);
    assign on_cur     = slot_start ? ((r_digit == '0) ? r_on_pre[0] : r_on_pre[1])
                                   : r_on_ticks;
    assign digit_next = (r_digit == ssmd_pkg::DIGIT_W'(ssmd_pkg::DIGITS - 1))
                      ? '0 : r_digit + 1'b1;
    assign cnt_inc    = {1'b0, r_count} + 1'b1;
    assign on_len     = {1'b0, on_cur} - 1'b1;
    // blank phase length follows the slot length as it is now
    assign off_time   = (r_slot > on_cur) ? r_slot - on_cur : '0;
    assign blank_len  = (off_time > ssmd_pkg::SLOT_W'(1)) ? off_time - 1'b1 : '0;
    assign cur_mask   = (slot_start && r_digit == '0) ? r_shown[r_digit] : r_latched[r_digit];

    // next state: phase, count and digit after this tick
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_digit = r_digit;
        case (r_phase)
            ssmd_pkg::PH_PRE: begin
                n_count = '0;
                // a one-tick on-time leaves no enabled ticks at all
                n_phase = (on_cur == ssmd_pkg::SLOT_W'(1)) ? ssmd_pkg::PH_OFF : ssmd_pkg::PH_ON;
            end
            ssmd_pkg::PH_ON: begin
                if (cnt_inc >= on_len) begin
                    n_phase = ssmd_pkg::PH_OFF;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc[ssmd_pkg::SLOT_W-1:0];
                end
            end
            ssmd_pkg::PH_OFF: begin
                n_count = '0;
                if (blank_len == '0) begin
                    n_phase = ssmd_pkg::PH_PRE;
                    n_digit = digit_next;
                end else begin
                    n_phase = ssmd_pkg::PH_BLANK;
                end
            end
            ssmd_pkg::PH_BLANK: begin
                if (cnt_inc >= {1'b0, blank_len}) begin
                    n_phase = ssmd_pkg::PH_PRE;
                    n_count = '0;
                    n_digit = digit_next;
                end else begin
                    n_count = cnt_inc[ssmd_pkg::SLOT_W-1:0];
                end
            end
            default: begin
                n_phase = ssmd_pkg::PH_PRE;
                n_count = '0;
            end
        endcase
    end

    // outputs for this tick
    always_comb begin
        n_seg = cur_mask;
        n_en  = '0;
        if (32'(r_digit) < ssmd_pkg::EN_W) begin
            n_en = ssmd_pkg::EN_W'(1) << r_digit;
        end
        case (r_phase)
            ssmd_pkg::PH_ON:    ;
            ssmd_pkg::PH_BLANK: begin
                n_seg = '0;
                n_en  = '0;
            end
            default:            n_en = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < ssmd_pkg::DIGITS; d++) begin
                r_shown[d]   <= '0;
                r_latched[d] <= '0;
            end
            r_digit    <= '0;
            r_phase    <= ssmd_pkg::PH_PRE;
            r_count    <= '0;
            r_on_ticks <= '0;
        end else if (a_fire) begin
            if (a_tick) begin
                if (slot_start) begin
                    r_on_ticks <= on_cur;
                    if (r_digit == '0) begin
                        for (int d = 0; d < ssmd_pkg::DIGITS; d++) begin
                            r_latched[d] <= r_shown[d];
                        end
                    end
                end
                r_phase <= n_phase;
                r_count <= n_count;
                r_digit <= n_digit;
            end else if (32'(r_a_pos) < ssmd_pkg::DIGITS) begin
                // set a digit; unused op is dropped
                if (r_a_op == ssmd_pkg::OP_DIGIT) begin
                    r_shown[ssmd_pkg::DIGIT_W'(r_a_pos)] <= ssmd_pkg::digit_mask(r_a_value);
                end else if (r_a_op == ssmd_pkg::OP_RAW) begin
                    r_shown[ssmd_pkg::DIGIT_W'(r_a_pos)] <= r_a_value[ssmd_pkg::SEG_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [ssmd_pkg::SEG_W-1:0] r_out_seg;
    logic [ssmd_pkg::EN_W-1:0]  r_out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= a_fire && a_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire && a_tick) begin
            r_out_seg <= n_seg;
            r_out_en  <= n_en;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segment_lines = r_out_seg;
    assign o_enable_lines  = r_out_en;

`ifndef SYNTHESIS
    a_no_take_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold != '0 |-> o_stall)
        else $error("item taken while on-time table settles");

    a_on_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ssmd_pkg::PH_ON |-> r_count < r_on_ticks)
        else $error("on-phase count beyond on-time");

    a_on_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != ssmd_pkg::PH_PRE |-> r_on_ticks != '0)
        else $error("slot running with zero on-time");

    a_digit_at_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_digit) |-> (r_phase == ssmd_pkg::PH_PRE && r_count == '0))
        else $error("digit advanced outside a slot boundary");
`endif

endmodule

// ===== test/ssmd_scan_checker.sv =====
module ssmd_scan_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel as seen by the block
    input  logic                            i_item_valid,
    input  logic                            i_item_stall,
    input  logic [1:0]                      i_op,
    input  logic                            i_position,
    input  logic [7:0]                      i_value,
    // result channel
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic [ssmd_pkg::SEG_W-1:0]      i_segment_lines,
    input  logic [ssmd_pkg::EN_W-1:0]       i_enable_lines,
    // register writes
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ssmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_failures,
    output int                              o_pending,
    output int                              o_checked
);

    localparam int unsigned FULL_SCALE   = 255;
    localparam int unsigned DECIMAL_BASE = 10;

    typedef struct packed {
        logic [ssmd_pkg::SEG_W-1:0] seg;
        logic [ssmd_pkg::EN_W-1:0]  en;
    } t_lines;

    // shadow of the block's registers and scan state
    logic [ssmd_pkg::SLOT_W-1:0]   slot_len;
    logic [ssmd_pkg::BRIGHT_W-1:0] bright_ones;
    logic [ssmd_pkg::BRIGHT_W-1:0] bright_tens;
    logic [ssmd_pkg::SEG_W-1:0]    shown_mask   [ssmd_pkg::DIGITS];
    logic [ssmd_pkg::SEG_W-1:0]    latched_mask [ssmd_pkg::DIGITS];
    logic [ssmd_pkg::DIGIT_W-1:0]  scan_digit;
    ssmd_pkg::t_phase              slot_phase;
    logic [ssmd_pkg::SLOT_W-1:0]   phase_ticks;
    logic [ssmd_pkg::SLOT_W-1:0]   on_len;

    t_lines lines_due [$];
    int     fail_count = 0;
    int     checked    = 0;

    function automatic logic [ssmd_pkg::SEG_W-1:0] font(input int unsigned digit);
        case (digit)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            default: return 7'h6F;
        endcase
    endfunction

    function automatic int unsigned phase_len(input ssmd_pkg::t_phase ph);
        int unsigned spare;
        spare = 0;
        case (ph)
            ssmd_pkg::PH_PRE, ssmd_pkg::PH_OFF: return 1;
            ssmd_pkg::PH_ON:                    return 32'(on_len) - 1;
            default: begin
                // blank length follows the slot length as it is now
                if (slot_len > on_len)
                    spare = 32'(slot_len) - 32'(on_len);
                return (spare > 1) ? spare - 1 : 0;
            end
        endcase
    endfunction

    task automatic scan_tick(output t_lines lines);
        int unsigned on_time;
        int unsigned count;
        int unsigned guard;
        logic        wrapped;
        logic [7:0]  bright;
        if (slot_phase == ssmd_pkg::PH_PRE && phase_ticks == 0) begin
            // refresh cycle starts with the ones digit: latch every mask
            if (scan_digit == 0)
                for (int d = 0; d < ssmd_pkg::DIGITS; d++)
                    latched_mask[d] = shown_mask[d];
            bright  = (scan_digit == 0) ? bright_ones : bright_tens;
            on_time = (32'(slot_len) * 32'(bright)) / FULL_SCALE;
            if (on_time < 1)
                on_time = 1;
            on_len = on_time[ssmd_pkg::SLOT_W-1:0];
        end

        lines.seg = latched_mask[scan_digit];
        lines.en  = ssmd_pkg::EN_W'(1) << scan_digit;
        if (slot_phase == ssmd_pkg::PH_BLANK) begin
            lines.seg = '0;
            lines.en  = '0;
        end else if (slot_phase != ssmd_pkg::PH_ON) begin
            lines.en = '0;
        end

        // advance, skipping phases of zero length
        count   = 32'(phase_ticks) + 1;
        wrapped = 1'b0;
        for (guard = 0; guard < 5 && !wrapped && count >= phase_len(slot_phase); guard++) begin
            count = 0;
            if (slot_phase == ssmd_pkg::PH_BLANK) begin
                slot_phase = ssmd_pkg::PH_PRE;
                scan_digit = ssmd_pkg::DIGIT_W'((32'(scan_digit) + 1) % ssmd_pkg::DIGITS);
                wrapped    = 1'b1;
            end else begin
                slot_phase = ssmd_pkg::t_phase'(slot_phase + 2'd1);
            end
        end
        phase_ticks = count[ssmd_pkg::SLOT_W-1:0];
    endtask

    always @(posedge i_clk) begin : track
        t_lines want;
        if (!i_rst_n) begin
            slot_len    = ssmd_pkg::SLOT_RESET;
            bright_ones = ssmd_pkg::BRIGHT_RESET;
            bright_tens = ssmd_pkg::BRIGHT_RESET;
            for (int d = 0; d < ssmd_pkg::DIGITS; d++) begin
                shown_mask[d]   = '0;
                latched_mask[d] = '0;
            end
            scan_digit  = '0;
            slot_phase  = ssmd_pkg::PH_PRE;
            phase_ticks = '0;
            on_len      = '0;
            lines_due.delete();
            fail_count  = 0;
            checked     = 0;
            o_failures <= 0;
            o_pending  <= 0;
            o_checked  <= 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                checked++;
                if (lines_due.size() == 0) begin
                    $error("result with no tick waiting: segment_lines %02h enable_lines %0b",
                           i_segment_lines, i_enable_lines);
                    fail_count++;
                end else begin
                    want = lines_due.pop_front();
                    if (i_segment_lines !== want.seg) begin
                        $error("segment_lines: expected %02h, got %02h",
                               want.seg, i_segment_lines);
                        fail_count++;
                    end
                    if (i_enable_lines !== want.en) begin
                        $error("enable_lines: expected %0b, got %0b",
                               want.en, i_enable_lines);
                        fail_count++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ssmd_pkg::CFG_SLOT:        slot_len    = i_cfg_data;
                    ssmd_pkg::CFG_BRIGHT_ONES: bright_ones = i_cfg_data[ssmd_pkg::BRIGHT_W-1:0];
                    ssmd_pkg::CFG_BRIGHT_TENS: bright_tens = i_cfg_data[ssmd_pkg::BRIGHT_W-1:0];
                    default: ;
                endcase
            end

            if (i_item_valid && !i_item_stall) begin
                case (i_op)
                    ssmd_pkg::OP_TICK: begin
                        scan_tick(want);
                        lines_due.push_back(want);
                    end
                    ssmd_pkg::OP_DIGIT:
                        shown_mask[i_position] = font(32'(i_value) % DECIMAL_BASE);
                    ssmd_pkg::OP_RAW:
                        shown_mask[i_position] = i_value[ssmd_pkg::SEG_W-1:0];
                    default: ;
                endcase
            end

            o_failures <= fail_count;
            o_pending  <= lines_due.size();
            o_checked  <= checked;
        end
    end

endmodule

// ===== test/tb.sv =====
module tb;

    // no package name for the spare op code or the spare register index
    localparam logic [1:0]                     OP_UNUSED = 2'd3;
    localparam logic [ssmd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // length of the one long output hold, in cycles
    localparam int                             LONG_HOLD = 250;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic [1:0]                      i_op        = ssmd_pkg::OP_TICK;
    logic                            i_position  = 1'b0;
    logic [7:0]                      i_value     = '0;
    logic                            i_stall     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [ssmd_pkg::CFG_IDX_W-1:0]  i_cfg_index = ssmd_pkg::CFG_SLOT;
    logic [ssmd_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            o_stall;
    logic                            o_valid;
    logic                            o_cfg_ready;
    logic [ssmd_pkg::SEG_W-1:0]      o_segment_lines;
    logic [ssmd_pkg::EN_W-1:0]       o_enable_lines;

    // idling knobs: sender gap odds live in the stimulus process,
    // receiver stall odds and the long hold request go to the sink process
    int   send_gap_pct   = 10;
    int   sink_stall_pct = 65;
    logic hold_request   = 1'b0;

    int items_sent = 0;
    int cfg_writes = 0;
    int failures;
    int lines_pending;
    int lines_checked;

    seven_segment_mux_dimmer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_segment_lines (o_segment_lines),
        .o_enable_lines  (o_enable_lines),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    ssmd_scan_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (i_valid),
        .i_item_stall    (o_stall),
        .i_op            (i_op),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_segment_lines (o_segment_lines),
        .i_enable_lines  (o_enable_lines),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_failures      (failures),
        .o_pending       (lines_pending),
        .o_checked       (lines_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("seven_segment_mux_dimmer: mismatch");
        $finish;
    end

    // Result sink: stall at random, and once hold off for a long stretch so
    // that both pipeline stages fill and the block stalls its item input.
    initial begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    // Offer one item and hold it until the block takes it. Valid stays high
    // on return so items can follow back to back.
    task automatic push_item(input logic [1:0] op, input logic pos, input logic [7:0] val);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        // idling schedule: sender light / sink heavy, then swapped, then none
        if (items_sent == 380) begin
            send_gap_pct    = 65;
            sink_stall_pct <= 10;
        end else if (items_sent == 760) begin
            send_gap_pct    = 0;
            sink_stall_pct <= 0;
        end else if (items_sent == 900) begin
            hold_request <= 1'b1;
        end
    endtask

    // Drop valid, wait for every pending scan result, then let the block idle
    // in case a mask write is still in flight.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (lines_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ssmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssmd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    // mostly random levels, with both ends showing up often
    function automatic logic [7:0] pick_brightness();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Retune while idle, then run random items: ticks dominate so the scan
    // walks through many slots, with mask writes and spare ops mixed in.
    task automatic run_phase(input logic [15:0] slot, input logic [7:0] b_ones,
                             input logic [7:0] b_tens, input int n);
        int pick;
        settle();
        cfg_write(ssmd_pkg::CFG_SLOT, slot);
        // brightness sits in the low byte; junk above it must be dropped
        cfg_write(ssmd_pkg::CFG_BRIGHT_ONES, {8'($urandom_range(255)), b_ones});
        cfg_write(ssmd_pkg::CFG_BRIGHT_TENS, {8'($urandom_range(255)), b_tens});
        repeat (n) begin
            pick = $urandom_range(99);
            push_item((pick < 72) ? ssmd_pkg::OP_TICK : (pick < 84) ? ssmd_pkg::OP_DIGIT :
                      (pick < 97) ? ssmd_pkg::OP_RAW : OP_UNUSED,
                      1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short slot before the first tick, so the scan never sits in a
        // thousand-tick on phase; brightness keeps its reset level here.
        cfg_write(ssmd_pkg::CFG_SLOT, 16'd5);
        cfg_write(CFG_SPARE, 16'hFFFF);

        // directed: blank first tick, raw masks with and without bit 7,
        // spare op, every decimal digit (values past 9 wrap), top value
        push_item(ssmd_pkg::OP_TICK, 1'b0, 8'h00);
        push_item(ssmd_pkg::OP_RAW, 1'b0, 8'h7F);
        push_item(ssmd_pkg::OP_RAW, 1'b1, 8'h80);
        push_item(OP_UNUSED, 1'b1, 8'hFF);
        for (int d = 0; d < 10; d++)
            push_item(ssmd_pkg::OP_DIGIT, 1'(d), 8'(d + 10 * $urandom_range(24)));
        push_item(ssmd_pkg::OP_DIGIT, 1'b0, 8'hFF);
        repeat (10)
            push_item(ssmd_pkg::OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));

        // extremes: shortest legal slot, full and zero brightness
        run_phase(16'd2, 8'd255, 8'd0, 100);
        run_phase(16'd3, 8'd0, 8'd255, 100);
        // short slots: on time clamps to one tick, blank phase empty
        run_phase(16'd1, 8'd255, 8'd128, 60);
        run_phase(16'd0, 8'd7, 8'd255, 60);
        // longest slot at minimum on time: long blank, cut short by retune
        run_phase(16'hFFFF, 8'd0, 8'd0, 80);

        repeat (8)
            run_phase(16'($urandom_range(24, 2)), pick_brightness(), pick_brightness(), 75);

        // largest on-time product last, since its on phase never ends here
        run_phase(16'hFFFF, 8'd255, 8'd255, 80);
        settle();

        $display("tb: %0d items driven, %0d scan results compared, %0d register writes",
                 items_sent, lines_checked, cfg_writes);
        $display("tb: slots 0 to 65535 ticks, brightness 0 to 255, one %0d-cycle output hold",
                 LONG_HOLD);
        if (failures == 0)
            $display("seven_segment_mux_dimmer: match");
        else
            $display("seven_segment_mux_dimmer: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/ssmd_pkg.sv
design/seven_segment_mux_dimmer.sv
test/ssmd_scan_checker.sv
test/tb.sv
